// ----- rtl/bbsf_pkg.sv -----
// Shared constants and types for the bounded byte stream FIFO.
// No dependencies; the top level and the byte store use these sizes.
`default_nettype none

package bbsf_pkg;

    // Byte store depth and the widths that follow from it
    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    // Fixed field widths of the stream words
    localparam int CAP_W   = 13;
    localparam int ACT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 13;
    localparam int FLD_W   = 13;
    localparam int TOT_W   = 64;
    localparam int CMP_W   = (CAP_W > CNT_W) ? ((CAP_W > REQ_W) ? CAP_W : REQ_W)
                                             : ((CNT_W > REQ_W) ? CNT_W : REQ_W);

    // Input word layout (tdata)
    localparam int IN_DATA_W = 24;

    // Output word layout (tdata), lowest bit first
    localparam int O_ACC   = 0;
    localparam int O_POP   = O_ACC + 1;
    localparam int O_HVLD  = O_POP + FLD_W;
    localparam int O_HEAD  = O_HVLD + 1;
    localparam int O_BUF   = O_HEAD + BYTE_W;
    localparam int O_SPACE = O_BUF + FLD_W;
    localparam int O_CLS   = O_SPACE + FLD_W;
    localparam int O_FIN   = O_CLS + 1;
    localparam int O_PUSHT = O_FIN + 1;
    localparam int O_POPT  = O_PUSHT + TOT_W;
    localparam int O_USED  = O_POPT + TOT_W;
    localparam int OUT_DATA_W = ((O_USED + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_STATUS = 2'd3
    } action_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_byte_stream_fifo.sv -----
// Top level of the bounded byte stream FIFO: handshakes, pointer and count
// update, head read from bbsf_ram, output register. Uses bbsf_pkg, bbsf_ram.
`default_nettype none

// Byte FIFO bounded by a configurable capacity, with an end-of-stream mark.
// Each input word carries an action in s_tuser (push, pop, close, status) and
// yields exactly one result word describing the state after that action.
// Sequence: an input word is accepted in ST_IDLE, where the read
// pointer, fill count, closed mark and the two 64-bit totals are updated, a
// pushed byte is written to the byte store and the new head address is read;
// the read data comes from the store's registered port in ST_LOAD, where the head
// byte is folded into the result and the result is loaded into the output
// register. The block takes the next word while that result still waits on
// m_tready; only a second result behind an untaken one stalls it. The store
// is never cleared: a head entry is only read once it has been written, so no
// clearing pass is needed and the block is ready right out of reset.
// Capacity is written through cfg_valid/cfg_data (cfg_ready is always high)
// and must only change while no word is in flight; values above the store
// depth act as the depth, zero refuses every push.

module bounded_byte_stream_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // data_byte [7:0], pop_count [20:8], zero [23:21]
    input  wire logic [bbsf_pkg::IN_DATA_W-1:0]     s_tdata,
    // action [1:0]
    input  wire logic [bbsf_pkg::ACT_W-1:0]         s_tuser,
    // Result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // accepted [0], popped_now [13:1], head_valid [14], head_byte [22:15],
    // buffered [35:23], space_left [48:36], is_closed_flag [49],
    // finished [50], pushed_total [114:51], popped_total [178:115], zero above
    output logic [bbsf_pkg::OUT_DATA_W-1:0]         m_tdata,
    // Capacity register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bbsf_pkg::CAP_W-1:0]         cfg_data
);

    localparam int ADDR_W = bbsf_pkg::ADDR_W;
    localparam int CNT_W  = bbsf_pkg::CNT_W;
    localparam int SUM_W  = bbsf_pkg::SUM_W;
    localparam int CMP_W  = bbsf_pkg::CMP_W;
    localparam int BYTE_W = bbsf_pkg::BYTE_W;
    localparam int FLD_W  = bbsf_pkg::FLD_W;
    localparam int TOT_W  = bbsf_pkg::TOT_W;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    // Control and architectural state
    state_t                       state_reg;
    logic [bbsf_pkg::CAP_W-1:0]   cap_reg;
    logic [ADDR_W-1:0]            rp_reg,   rp_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic                         closed_reg, closed_next;
    logic [TOT_W-1:0]             push_tot_reg, push_tot_next;
    logic [TOT_W-1:0]             pop_tot_reg,  pop_tot_next;

    // Per-word results held across the read cycle
    logic                         acc_reg,  acc_next;
    logic [CNT_W-1:0]             popped_reg, popped_next;
    logic                         fwd_reg;
    logic [BYTE_W-1:0]            fwd_byte_reg;

    logic                         m_tvalid_reg;
    logic [bbsf_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Decoded input word
    bbsf_pkg::action_t            action;
    logic [BYTE_W-1:0]            data_byte;
    logic [bbsf_pkg::REQ_W-1:0]   pop_count;
    logic                         in_fire;

    logic [CNT_W-1:0]             eff_cap;
    logic                         push_ok;
    logic [SUM_W-1:0]             wsum;
    logic [ADDR_W-1:0]            waddr;
    logic [SUM_W-1:0]             rsum;
    logic [CNT_W-1:0]             pop_amt;
    logic                         out_free;

    logic [BYTE_W-1:0]            ram_rdata;
    logic [BYTE_W-1:0]            head_byte;
    logic [CNT_W-1:0]             space;

    assign action    = bbsf_pkg::action_t'(s_tuser);
    assign data_byte = s_tdata[BYTE_W-1:0];
    assign pop_count = s_tdata[BYTE_W +: bbsf_pkg::REQ_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Clamp the configured capacity to the store depth
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(bbsf_pkg::DEPTH))
        begin
            eff_cap = CNT_W'(bbsf_pkg::DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign push_ok = !closed_reg && (fill_reg < eff_cap);

    // Tail address: read pointer plus fill, wrapped once
    assign wsum  = SUM_W'(rp_reg) + SUM_W'(fill_reg);
    assign waddr = (wsum >= SUM_W'(bbsf_pkg::DEPTH)) ?
                   ADDR_W'(wsum - SUM_W'(bbsf_pkg::DEPTH)) : ADDR_W'(wsum);

    // Pop amount, clamped to what is buffered
    assign pop_amt = (CMP_W'(pop_count) < CMP_W'(fill_reg)) ?
                     CNT_W'(pop_count) : fill_reg;
    assign rsum    = SUM_W'(rp_reg) + SUM_W'(pop_amt);

    // Next architectural state for the word being accepted
    always_comb
    begin
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        closed_next   = closed_reg;
        push_tot_next = push_tot_reg;
        pop_tot_next  = pop_tot_reg;
        acc_next      = 1'b0;
        popped_next   = '0;
        case (action)
            bbsf_pkg::ACT_PUSH:
            begin
                if (push_ok)
                begin
                    fill_next     = fill_reg + CNT_W'(1);
                    push_tot_next = push_tot_reg + TOT_W'(1);
                    acc_next      = 1'b1;
                end
            end
            bbsf_pkg::ACT_POP:
            begin
                rp_next      = (rsum >= SUM_W'(bbsf_pkg::DEPTH)) ?
                               ADDR_W'(rsum - SUM_W'(bbsf_pkg::DEPTH)) : ADDR_W'(rsum);
                fill_next    = fill_reg - pop_amt;
                pop_tot_next = pop_tot_reg + TOT_W'(pop_amt);
                popped_next  = pop_amt;
            end
            bbsf_pkg::ACT_CLOSE:
            begin
                closed_next = 1'b1;
            end
            default:
            begin
                // status only: change nothing
            end
        endcase
    end

    // Byte store: write the pushed byte, read the new head in the same cycle
    bbsf_ram #(
        .DEPTH_P (bbsf_pkg::DEPTH),
        .WIDTH_P (BYTE_W),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && (action == bbsf_pkg::ACT_PUSH) && push_ok),
        .waddr (waddr),
        .wdata (data_byte),
        .re    (in_fire),
        .raddr (rp_next),
        .rdata (ram_rdata)
    );

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bbsf_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Pointer, count, mark and totals advance on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            fill_reg     <= '0;
            closed_reg   <= 1'b0;
            push_tot_reg <= '0;
            pop_tot_reg  <= '0;
        end
        else if (in_fire)
        begin
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            closed_reg   <= closed_next;
            push_tot_reg <= push_tot_next;
            pop_tot_reg  <= pop_tot_next;
        end
    end

    // Per-word results; a push into an empty buffer writes the very entry
    // being read, so forward the byte instead of the stale RAM data
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            acc_reg      <= acc_next;
            popped_reg   <= popped_next;
            fwd_reg      <= acc_next && (fill_reg == '0);
            fwd_byte_reg <= data_byte;
        end
    end

    assign head_byte = (fill_reg == '0) ? '0 : (fwd_reg ? fwd_byte_reg : ram_rdata);
    assign space     = (fill_reg < eff_cap) ? (eff_cap - fill_reg) : '0;

    // Assemble the result word for the item in its read cycle
    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[bbsf_pkg::O_ACC]             = acc_reg;
        m_tdata_next[bbsf_pkg::O_POP +: FLD_W]    = FLD_W'(popped_reg);
        m_tdata_next[bbsf_pkg::O_HVLD]            = (fill_reg != '0);
        m_tdata_next[bbsf_pkg::O_HEAD +: BYTE_W]  = head_byte;
        m_tdata_next[bbsf_pkg::O_BUF +: FLD_W]    = FLD_W'(fill_reg);
        m_tdata_next[bbsf_pkg::O_SPACE +: FLD_W]  = FLD_W'(space);
        m_tdata_next[bbsf_pkg::O_CLS]             = closed_reg;
        m_tdata_next[bbsf_pkg::O_FIN]             = closed_reg && (fill_reg == '0);
        m_tdata_next[bbsf_pkg::O_PUSHT +: TOT_W]  = push_tot_reg;
        m_tdata_next[bbsf_pkg::O_POPT +: TOT_W]   = pop_tot_reg;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // drop a result once it has been taken
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (in_fire)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    // hold here until the previous result has been taken
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= m_tdata_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The fill count never exceeds the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(bbsf_pkg::DEPTH))
        else $error("fill count above store depth");

    // A stored push bumps the push total by exactly one
    a_push_total: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (action == bbsf_pkg::ACT_PUSH) && push_ok) |=>
        (push_tot_reg == $past(push_tot_reg) + TOT_W'(1)))
        else $error("push total did not advance on a stored byte");

    // Once the output side is free, the pending result is presented next cycle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOAD) && out_free) |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("pending result not loaded");

endmodule

`default_nettype wire

// ----- rtl/bbsf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Self-contained; read returns the old contents on a same-address write.
`default_nettype none

module bbsf_ram #(
    parameter int DEPTH_P = 4096,
    parameter int WIDTH_P = 8,
    parameter int ADDR_W  = $clog2(DEPTH_P)
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [WIDTH_P-1:0] wdata,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic      [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
